/* sv/hafe_pkg.sv */
package hafe_pkg;

   localparam logic [7:0]  FLAG_BYTE = 8'h7E;
   localparam logic [7:0]  ESC_BYTE  = 8'h7D;
   localparam logic [7:0]  ESC_XOR   = 8'h20;
   localparam logic [15:0] CRC_POLY  = 16'h8408;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;

   // queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   // serialiser steps
   localparam logic [2:0] ST_OPEN   = 3'd0;
   localparam logic [2:0] ST_DATA   = 3'd1;
   localparam logic [2:0] ST_FCS_LO = 3'd2;
   localparam logic [2:0] ST_FCS_HI = 3'd3;
   localparam logic [2:0] ST_CLOSE  = 3'd4;

   // one classified payload beat
   typedef struct packed {
      logic        opens;
      logic [7:0]  data;
      logic        last_item;
      logic [15:0] fcs;
   } hafe_item_type;

   // crc-16/x.25 over one byte, lsb first
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* sv/hafe_front.sv */
module hafe_front
   import hafe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // payload_byte
   input  logic          req_tlast,   // frame_last
   output logic          push_valid,
   input  logic          push_ready,
   output hafe_item_type push_item
);

   logic [15:0] crc_ff, crc_in;
   logic        in_frame_ff, in_frame_in;
   logic [15:0] crc_next;
   logic        accept;

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign accept     = req_tvalid && push_ready;

   // running crc and classification of the beat
   always_comb begin
      crc_next            = crc_update(crc_ff, req_tdata);
      push_item.opens     = !in_frame_ff;
      push_item.data      = req_tdata;
      push_item.last_item = req_tlast;
      push_item.fcs       = ~crc_next;
      crc_in              = crc_ff;
      in_frame_in         = in_frame_ff;
      if (accept) begin
         crc_in      = req_tlast ? CRC_INIT : crc_next;
         in_frame_in = !req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff      <= CRC_INIT;
         in_frame_ff <= 1'b0;
      end else begin
         crc_ff      <= crc_in;
         in_frame_ff <= in_frame_in;
      end
   end

endmodule

/* sv/hafe_fifo.sv */
module hafe_fifo
   import hafe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  hafe_item_type push_item,
   output logic          pop_valid,
   input  logic          pop_ready,
   output hafe_item_type pop_item
);

   hafe_item_type        mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != FIFO_CW'(FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* sv/hafe_back.sv */
module hafe_back
   import hafe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   output logic          pop_ready,
   input  hafe_item_type pop_item,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata,   // line_byte
   output logic          rsp_tuser,   // frame_done
   output logic          rsp_tlast    // run_last
);

   hafe_item_type cur_ff, cur_in;
   logic          cur_valid_ff, cur_valid_in;
   logic [2:0]    step_ff, step_in;
   logic          esc_ff, esc_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;
   logic          rsp_user_ff, rsp_user_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          out_free, advance, finish, do_pop;
   logic [7:0]    sel, emit_byte;
   logic          emit_done;
   logic [2:0]    step_adv;
   logic          esc_adv;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign advance  = cur_valid_ff && out_free;

   // pick the byte to send for this step, with escaping
   always_comb begin
      sel       = 8'h00;
      emit_byte = FLAG_BYTE;
      emit_done = 1'b0;
      finish    = 1'b0;
      step_adv  = step_ff;
      esc_adv   = 1'b0;
      case (step_ff)
         ST_DATA:   sel = cur_ff.data;
         ST_FCS_LO: sel = cur_ff.fcs[7:0];
         ST_FCS_HI: sel = cur_ff.fcs[15:8];
         default:   sel = 8'h00;
      endcase
      case (step_ff)
         ST_OPEN: begin
            emit_byte = FLAG_BYTE;
            step_adv  = ST_DATA;
         end
         ST_DATA, ST_FCS_LO, ST_FCS_HI: begin
            if (!esc_ff && (sel inside {FLAG_BYTE, ESC_BYTE})) begin
               emit_byte = ESC_BYTE;
               esc_adv   = 1'b1;
            end else begin
               emit_byte = esc_ff ? (sel ^ ESC_XOR) : sel;
               if (step_ff == ST_DATA) begin
                  step_adv = ST_FCS_LO;
                  finish   = !cur_ff.last_item;
               end else if (step_ff == ST_FCS_LO) begin
                  step_adv = ST_FCS_HI;
               end else begin
                  step_adv = ST_CLOSE;
               end
            end
         end
         ST_CLOSE: begin
            emit_byte = FLAG_BYTE;
            emit_done = 1'b1;
            finish    = 1'b1;
         end
         default: begin
            finish = 1'b1;
         end
      endcase
   end

   assign pop_ready = !cur_valid_ff || (advance && finish);
   assign do_pop    = pop_valid && pop_ready;

   // current item and step sequencing
   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      step_in      = step_ff;
      esc_in       = esc_ff;
      if (advance) begin
         step_in = step_adv;
         esc_in  = esc_adv;
      end
      if (do_pop) begin
         cur_in       = pop_item;
         cur_valid_in = 1'b1;
         step_in      = pop_item.opens ? ST_OPEN : ST_DATA;
         esc_in       = 1'b0;
      end else if (advance && finish) begin
         cur_valid_in = 1'b0;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_byte;
         rsp_user_in  = emit_done;
         rsp_last_in  = finish;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= ST_OPEN;
         esc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         step_ff      <= step_in;
         esc_ff       <= esc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* sv/hdlc_async_frame_encoder.sv */
// path: a payload beat passes the queue, the current-item register and the output register
// throughput: the serialiser sends one line byte per cycle unless the output stalls; an item
// is 1 to 8 line bytes (flags, escapes, two fcs bytes); a four-entry queue decouples input from output
// reset: synchronous, active high; crc returns to 0xffff, no frame open, queue and
// output register empty
module hdlc_async_frame_encoder
   import hafe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // payload_byte
   input  logic       req_tlast,   // frame_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // line_byte
   output logic       rsp_tuser,   // frame_done
   output logic       rsp_tlast    // run_last
);

   logic          push_valid, push_ready;
   hafe_item_type push_item;
   logic          pop_valid, pop_ready;
   hafe_item_type pop_item;

   // classify beats and keep the crc
   hafe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // decoupling queue
   hafe_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // byte serialiser with stuffing
   hafe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* sv/hafe_checker.sv */
module hafe_checker
   import hafe_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // closing flag is a flag and ends its run
   a_close_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata == FLAG_BYTE))
      else $error("frame end not on closing flag");

   // an escape byte never ends a run, so its partner follows in the same run
   a_esc_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata == ESC_BYTE) |-> !rsp_tlast)
      else $error("escape byte ends a run");

   // output empty straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind hdlc_async_frame_encoder hafe_checker u_hafe_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
